FILE: design/mbce_pkg.sv
`default_nettype none
package mbce_pkg;

	localparam int COORD_BITS        = 12;
	localparam int DEF_MAX_ROW_BYTES = 256;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 12;
	// wide enough for any byte position in bits and for the clamped stride
	localparam int POS_W             = 16;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_ALIGN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OPAQUE_MODE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd7;

	typedef struct packed {
		logic [7:0] src_byte;
		logic       final_byte;
	} in_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] pix_x;
		logic [COORD_BITS-1:0] pix_y;
		logic [7:0]            pix_color;
		logic                  run_last;
	} out_t;

	// one source byte ready for serialization; mask is MSB first like src
	typedef struct packed {
		logic [7:0]            mask;
		logic [7:0]            src;
		logic [COORD_BITS-1:0] xbase;
		logic [COORD_BITS-1:0] y;
	} job_t;

endpackage
`default_nettype wire

FILE: design/mbce_emit.sv
`default_nettype none
module mbce_emit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	input  wire mbce_pkg::job_t job,
	output logic               job_ready,
	input  wire logic [7:0]    fore_color,
	input  wire logic [7:0]    back_color,
	output logic               out_valid,
	input  wire logic          out_ready,
	output mbce_pkg::out_t     out_data
);

	logic           work_valid_q;
	mbce_pkg::job_t work_q;
	logic           out_valid_q;
	mbce_pkg::out_t out_q;

	logic [2:0] sel;
	logic [7:0] rest;
	logic       last;
	logic       out_load;
	logic       pop;
	logic       take;

	// highest set mask bit is the leftmost pending pixel
	always_comb begin
		sel = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (work_q.mask[i]) begin
				sel = 3'(i);
			end
		end
		rest = work_q.mask & ~(8'b1 << sel);
		last = (rest == 8'b0);
	end

	assign out_load  = !out_valid_q || out_ready;
	assign pop       = work_valid_q && out_load;
	assign job_ready = !work_valid_q || (out_load && last);
	assign take      = job_valid && job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_valid_q <= 1'b0;
		end else if (take) begin
			work_valid_q <= (job.mask != 8'b0);
		end else if (pop) begin
			work_valid_q <= !last;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			work_q <= job;
		end else if (pop) begin
			work_q.mask <= rest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= work_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.pix_x     <= work_q.xbase + mbce_pkg::COORD_BITS'(3'd7 - sel);
			out_q.pix_y     <= work_q.y;
			out_q.pix_color <= work_q.src[sel] ? fore_color : back_color;
			out_q.run_last  <= last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

FILE: design/mono_bitmap_color_expand.sv
// A source byte is taken into the work register and its first pixel moves to the
// output register. One pixel beat per cycle while out_ready is high; a byte with n
// pixels (at most 8) holds the input till its last pixel pops; an empty one does not.
// The pixel serializer (one work register, one output register) sets the rate.
// Reset (arst_n low, asynchronous): row_bytes returns to 1, the other config
// registers and the row and byte counters to 0, both pipeline stages empty.
`default_nettype none
module mono_bitmap_color_expand #(
	parameter int MAX_ROW_BYTES = mbce_pkg::DEF_MAX_ROW_BYTES
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire mbce_pkg::in_t                 in_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output mbce_pkg::out_t                     out_data,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [mbce_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mbce_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int BIR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
	localparam int PW    = mbce_pkg::POS_W;
	localparam int CB    = mbce_pkg::COORD_BITS;

	logic [11:0] width_q;
	logic [2:0]  bit_align_q;
	logic [8:0]  row_bytes_q;
	logic [7:0]  fore_color_q;
	logic [7:0]  back_color_q;
	logic        opaque_q;
	logic [11:0] origin_x_q;
	logic [11:0] origin_y_q;

	logic [BIR_W-1:0] byte_in_row_q;
	logic [CB-1:0]    row_index_q;

	logic [PW-1:0]  stride;
	logic [PW-1:0]  bir_ext;
	logic [PW-1:0]  pos_base;
	logic [PW-1:0]  first;
	logic [PW-1:0]  end_pos;
	logic [PW-1:0]  pos_k;
	logic           in_stride;
	logic           row_end;
	logic [7:0]     mask;
	mbce_pkg::job_t job;
	logic           in_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= '0;
			bit_align_q  <= '0;
			row_bytes_q  <= 9'd1;
			fore_color_q <= '0;
			back_color_q <= '0;
			opaque_q     <= 1'b0;
			origin_x_q   <= '0;
			origin_y_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mbce_pkg::REG_WIDTH:       width_q      <= cfg_data[11:0];
				mbce_pkg::REG_BIT_ALIGN:   bit_align_q  <= cfg_data[2:0];
				mbce_pkg::REG_ROW_BYTES:   row_bytes_q  <= cfg_data[8:0];
				mbce_pkg::REG_FORE_COLOR:  fore_color_q <= cfg_data[7:0];
				mbce_pkg::REG_BACK_COLOR:  back_color_q <= cfg_data[7:0];
				mbce_pkg::REG_OPAQUE_MODE: opaque_q     <= cfg_data[0];
				mbce_pkg::REG_ORIGIN_X:    origin_x_q   <= cfg_data[11:0];
				mbce_pkg::REG_ORIGIN_Y:    origin_y_q   <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// clamp stride to 1..MAX_ROW_BYTES
	always_comb begin
		if (row_bytes_q == 9'd0) begin
			stride = PW'(1);
		end else if (PW'(row_bytes_q) > PW'(MAX_ROW_BYTES)) begin
			stride = PW'(MAX_ROW_BYTES);
		end else begin
			stride = PW'(row_bytes_q);
		end
	end

	assign bir_ext   = PW'(byte_in_row_q);
	assign pos_base  = PW'({byte_in_row_q, 3'b000});
	assign first     = PW'(bit_align_q);
	assign end_pos   = PW'(bit_align_q) + PW'(width_q);
	assign in_stride = bir_ext < stride;
	assign row_end   = (bir_ext + PW'(1)) >= stride;

	// pixel k of the byte sits at mask bit 7-k
	always_comb begin
		mask  = 8'b0;
		pos_k = '0;
		for (int k = 0; k < 8; k++) begin
			pos_k = pos_base + PW'(k);
			mask[7-k] = in_stride && (pos_k >= first) && (pos_k < end_pos)
				&& (in_data.src_byte[7-k] || opaque_q);
		end
	end

	always_comb begin
		job.mask  = mask;
		job.src   = in_data.src_byte;
		job.xbase = CB'(PW'(origin_x_q) + pos_base - first);
		job.y     = origin_y_q + row_index_q;
	end

	assign in_take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_in_row_q <= '0;
			row_index_q   <= '0;
		end else if (in_take) begin
			if (in_data.final_byte) begin
				byte_in_row_q <= '0;
				row_index_q   <= '0;
			end else if (row_end) begin
				byte_in_row_q <= '0;
				row_index_q   <= row_index_q + CB'(1);
			end else begin
				byte_in_row_q <= byte_in_row_q + BIR_W'(1);
			end
		end
	end

	mbce_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (in_valid),
		.job        (job),
		.job_ready  (in_ready),
		.fore_color (fore_color_q),
		.back_color (back_color_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

`ifndef NO_ASSERTIONS
	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && in_data.final_byte |=> byte_in_row_q == '0 && row_index_q == '0)
		else $error("counters not cleared after final byte");

	a_byte_advance: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && !in_data.final_byte && !row_end
		|=> byte_in_row_q == $past(byte_in_row_q) + BIR_W'(1))
		else $error("byte counter did not advance");

	a_transparent_skip: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && ((mask & ~in_data.src_byte) != 8'b0) |-> opaque_q)
		else $error("clear bit scheduled in transparent mode");

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && !in_data.final_byte && row_end
		|=> byte_in_row_q == '0 && row_index_q == $past(row_index_q) + CB'(1))
		else $error("row advance wrong at row end");
`endif

endmodule
`default_nettype wire
